// ===== hdl/bssa_pkg.sv =====
package bssa_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 64;
  localparam int unsigned MASK_W = 64;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned LEN_W = 20;
  localparam int unsigned WAIT_W = 16;
  localparam int unsigned SUM_W = 27;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned DVD_W = SUM_W + 2;
  localparam int unsigned DIV_STEPS_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 200;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [LEN_W-1:0] CNT_MAX = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
  localparam logic [SUM_W-1:0] TARGET_RST = SUM_W'(6400000);
  localparam logic [CNT_W-1:0] BATCH_RST = CNT_W'(64);
  localparam logic [WAIT_W-1:0] AGE_RST = WAIT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_BATCH  = 2'd1,
    CFG_AGE    = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_ROUND = 1'b1
  } kind_e;

  typedef struct packed {
    logic load;
    logic init;
    logic div_go;
    logic sweep_go;
    logic upd;
    logic pick;
    logic dev;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic loop_ok;
    logic div_busy;
    logic sweep_done;
    logic sel_any;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/bssa_ctrl.sv =====
module bssa_ctrl
  import bssa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_SCAN, S_PICK, S_UPD, S_DEV, S_FIN
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
            state_d = S_FIN;
          end else begin
            cmd_o.init = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.loop_ok) begin
          cmd_o.div_go = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.sweep_go = 1'b1;
          state_d = S_UPD;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.sweep_go = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.sweep_done) state_d = S_PICK;
      end
      S_PICK: begin
        if (sts_i.sel_any) begin
          cmd_o.pick = 1'b1;
          state_d = S_CHECK;
        end else begin
          cmd_o.sweep_go = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        if (sts_i.sweep_done) state_d = S_DEV;
      end
      S_DEV: begin
        cmd_o.dev = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/bssa_dp.sv =====
module bssa_dp
  import bssa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [SUM_W-1:0]      cfg_data_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [LEN_W-1:0]      prompt_len_i,
  input  logic [LEN_W-1:0]      decode_total_i,
  input  logic [LEN_W-1:0]      decode_start_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned MEM_W = 3 * LEN_W + WAIT_W;
  localparam logic [IW:0] LAST_ADDR = (IW + 1)'(POOL_SLOTS);

  // configuration
  logic [SUM_W-1:0]  target_q;
  logic [CNT_W-1:0]  batch_q;
  logic [WAIT_W-1:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      batch_q <= BATCH_RST;
      age_q <= AGE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET: target_q <= cfg_data_i;
        CFG_BATCH:  batch_q <= cfg_data_i[CNT_W-1:0];
        CFG_AGE:    age_q <= cfg_data_i[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // slot memory: prompt, total, count, wait
  logic [MEM_W-1:0] mem [POOL_SLOTS];
  logic [MEM_W-1:0] rd_q;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [MEM_W-1:0] wr_data;

  logic [IW:0]   sw_addr_q;
  logic          sw_act_q;
  logic          rd_v_q;
  logic [IW-1:0] rd_idx_q;
  logic          sw_issue;

  logic [POOL_SLOTS-1:0] valid_q, picked_q, done_q;
  logic                  load_ok;

  assign load_ok = ({1'b0, slot_i} < (SLOT_W + 1)'(POOL_SLOTS));
  assign sw_issue = sw_act_q && (sw_addr_q < LAST_ADDR);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[sw_addr_q[IW-1:0]];
  end

  logic [LEN_W-1:0]  rd_prompt, rd_total, rd_count;
  logic [WAIT_W-1:0] rd_wait;
  assign {rd_prompt, rd_total, rd_count, rd_wait} = rd_q;

  logic              elig;
  logic [LEN_W:0]    rd_len;
  assign elig = rd_v_q && valid_q[rd_idx_q] && !picked_q[rd_idx_q];
  assign rd_len = {1'b0, rd_prompt} + {1'b0, rd_count};

  // update of one slot at the end of a round
  logic [LEN_W-1:0]  new_count;
  logic [WAIT_W-1:0] new_wait;
  logic              now_done;
  always_comb begin
    new_count = rd_count;
    new_wait = rd_wait;
    if (picked_q[rd_idx_q]) begin
      if (rd_count < CNT_MAX) new_count = rd_count + 1'b1;
      new_wait = '0;
    end else if (rd_wait < WAIT_MAX) begin
      new_wait = rd_wait + 1'b1;
    end
    now_done = (new_count >= rd_total);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = {rd_prompt, rd_total, new_count, new_wait};
    if (cmd_i.load) begin
      wr_en = load_ok;
      wr_addr = slot_i[IW-1:0];
      wr_data = {prompt_len_i, decode_total_i, decode_start_i, {WAIT_W{1'b0}}};
    end else if (cmd_i.upd && rd_v_q && valid_q[rd_idx_q]) begin
      wr_en = 1'b1;
    end
  end

  // sweep over the slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_addr_q <= '0;
      sw_act_q <= 1'b0;
      rd_v_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      rd_v_q <= sw_issue;
      if (sw_issue) begin
        rd_idx_q <= sw_addr_q[IW-1:0];
        sw_addr_q <= sw_addr_q + 1'b1;
      end
      if (cmd_i.sweep_go) begin
        sw_addr_q <= '0;
        sw_act_q <= 1'b1;
      end else if (sts_o.sweep_done) begin
        sw_act_q <= 1'b0;
      end
    end
  end

  // round totals
  logic [SUM_W-1:0] sum_q, dev_q;
  logic [CNT_W-1:0] cnt_q, forced_q;

  // divider for the ideal length
  logic [DVD_W-1:0]       dvd_q, quo_q;
  logic [CNT_W:0]         dvs_q;
  logic [CNT_W:0]         rem_q;
  logic [DIV_STEPS_W-1:0] dstep_q;
  logic                   dbusy_q;
  logic [CNT_W+1:0]       rem_sh;
  logic                   rem_ge;
  logic [CNT_W-1:0]       den;
  logic [SUM_W-1:0]       num;

  assign den = batch_q - cnt_q;
  assign num = target_q - sum_q;
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dstep_q <= '0;
    end else if (cmd_i.div_go) begin
      dbusy_q <= 1'b1;
      dstep_q <= DIV_STEPS_W'(DVD_W - 1);
    end else if (dbusy_q) begin
      dstep_q <= dstep_q - 1'b1;
      if (dstep_q == '0) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      dvd_q <= {1'b0, num, 1'b0} + DVD_W'(den);
      dvs_q <= {den, 1'b0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (dbusy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], rem_ge};
      rem_q <= rem_ge ? (CNT_W + 1)'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W:0];
    end
  end

  // candidate search
  logic              ffound_q, have_q;
  logic [IW-1:0]     fidx_q, bidx_q;
  logic [LEN_W:0]    flen_q, blen_q;
  logic [DVD_W-1:0]  best_q, len_diff;

  assign len_diff = ({8'd0, rd_len} > quo_q) ? ({8'd0, rd_len} - quo_q)
                                             : (quo_q - {8'd0, rd_len});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffound_q <= 1'b0;
      have_q <= 1'b0;
    end else if (cmd_i.sweep_go) begin
      ffound_q <= 1'b0;
      have_q <= 1'b0;
    end else if (!cmd_i.upd && elig) begin
      if (!ffound_q && rd_wait >= age_q) ffound_q <= 1'b1;
      if (!have_q || len_diff < best_q) have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cmd_i.upd && elig) begin
      if (!ffound_q && rd_wait >= age_q) begin
        fidx_q <= rd_idx_q;
        flen_q <= rd_len;
      end
      if (!have_q || len_diff < best_q) begin
        best_q <= len_diff;
        bidx_q <= rd_idx_q;
        blen_q <= rd_len;
      end
    end
  end

  logic             round_q;
  logic [IW-1:0]    sel_idx;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W+3:0] dev10;

  assign sel_idx = ffound_q ? fidx_q : bidx_q;
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(ffound_q ? flen_q : blen_q);
  assign dev10 = (SUM_W + 4)'({dev_q, 3'd0}) + (SUM_W + 4)'({dev_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      picked_q <= '0;
      done_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      forced_q <= '0;
      dev_q <= '0;
      round_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        round_q <= 1'b0;
        if (load_ok) valid_q[slot_i[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.init) begin
        round_q <= 1'b1;
        picked_q <= '0;
        done_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
        forced_q <= '0;
      end
      if (cmd_i.pick) begin
        picked_q[sel_idx] <= 1'b1;
        sum_q <= (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (ffound_q) forced_q <= forced_q + 1'b1;
      end
      if (cmd_i.upd && rd_v_q && valid_q[rd_idx_q] && now_done) begin
        valid_q[rd_idx_q] <= 1'b0;
        done_q[rd_idx_q] <= 1'b1;
      end
      if (cmd_i.dev) begin
        dev_q <= (sum_q > target_q) ? (sum_q - target_q) : (target_q - sum_q);
      end
    end
  end

  // result register
  logic                  out_v_q;
  logic [OUT_DATA_W-1:0] out_q;
  logic                  hit;

  assign hit = (cnt_q == batch_q) && (dev10 <= (SUM_W + 4)'(target_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (round_q) begin
        out_q <= {3'd0, MASK_W'(done_q), hit, forced_q, dev_q, sum_q, cnt_q,
                  MASK_W'(picked_q)};
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  assign sts_o.loop_ok = (cnt_q < batch_q) && (sum_q < target_q);
  assign sts_o.div_busy = dbusy_q;
  assign sts_o.sweep_done = sw_act_q && !sw_issue && !rd_v_q;
  assign sts_o.sel_any = ffound_q || have_q;
  assign sts_o.out_free = !out_v_q || out_ready_i;

endmodule

// ===== hdl/batch_steering_scheduler_agecap_unit.sv =====
// Age-capped batch steering over a pool of POOL_SLOTS request slots. A load
// transaction (tuser kind 0) writes one slot and returns an all-zero result.
// A round transaction (tuser kind 1) repeats, per pick, a check step, a
// restoring divide for the ideal length, one pass over the slot memory and
// a pick step, then a final update pass over the slots and a deviation
// step; when the pool runs out before the batch is full, one more search
// finds no candidate before the update pass. One item is worked on at a
// time; a finished result waits in the output register while the next
// transaction is taken.
module batch_steering_scheduler_agecap_unit
  import bssa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [SUM_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot, prompt_len, decode_total, decode_start
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // picked_mask, picked_count, picked_sum, deviation, forced_count, hit, done_mask
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bssa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .slot_i         (s_axis_tdata[5:0]),
    .prompt_len_i   (s_axis_tdata[25:6]),
    .decode_total_i (s_axis_tdata[45:26]),
    .decode_start_i (s_axis_tdata[65:46]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// ===== test/batch_steering_scheduler_agecap_unit_tb.sv =====
module batch_steering_scheduler_agecap_unit_tb;
  import bssa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned STALL_LIMIT = 30000;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  typedef struct {
    logic [MASK_W-1:0] picked_mask;
    logic [CNT_W-1:0]  picked_count;
    logic [SUM_W-1:0]  picked_sum;
    logic [SUM_W-1:0]  deviation;
    logic [CNT_W-1:0]  forced_count;
    logic              hit;
    logic [MASK_W-1:0] done_mask;
  } batch_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_TARGET;
  logic [SUM_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = KIND_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // scheduler state as predicted
  logic [LEN_W-1:0]  pool_prompt [SLOTS];
  logic [LEN_W-1:0]  pool_total [SLOTS];
  logic [LEN_W-1:0]  pool_decoded [SLOTS];
  logic [WAIT_W-1:0] pool_wait [SLOTS];
  bit                pool_live [SLOTS];
  logic [SUM_W-1:0]  cur_target = TARGET_RST;
  logic [CNT_W-1:0]  cur_batch = BATCH_RST;
  logic [WAIT_W-1:0] cur_age = AGE_RST;

  batch_res_t pending_batches[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit holdoff_req = 1'b0;
  bit quiet = 1'b0;

  batch_steering_scheduler_agecap_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic batch_res_t schedule_item(kind_e kind, logic [SLOT_W-1:0] slot,
                                               logic [LEN_W-1:0] plen, logic [LEN_W-1:0] dtot,
                                               logic [LEN_W-1:0] dstart);
    batch_res_t r;
    longint unsigned sum, num, den, ideal, best, len, d, dev;
    int sel, cnt, forced;
    bit by_age;
    r = '{default: '0};
    if (kind == KIND_LOAD) begin
      pool_prompt[slot] = plen;
      pool_total[slot] = dtot;
      pool_decoded[slot] = dstart;
      pool_wait[slot] = '0;
      pool_live[slot] = 1'b1;
      return r;
    end
    sum = 0;
    cnt = 0;
    forced = 0;
    while (cnt < cur_batch && sum < cur_target) begin
      sel = -1;
      by_age = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (pool_live[i] && !r.picked_mask[i] && pool_wait[i] >= cur_age) begin
          sel = i;
          by_age = 1'b1;
          break;
        end
      end
      if (sel < 0) begin
        num = cur_target - sum;
        den = cur_batch - cnt;
        ideal = (2 * num + den) / (2 * den);
        best = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!pool_live[i] || r.picked_mask[i]) continue;
          len = pool_prompt[i] + pool_decoded[i];
          d = (len > ideal) ? len - ideal : ideal - len;
          if (sel < 0 || d < best) begin
            best = d;
            sel = i;
          end
        end
      end
      if (sel < 0) break;
      r.picked_mask[sel] = 1'b1;
      sum += pool_prompt[sel] + pool_decoded[sel];
      if (sum > SUM_MAX) sum = SUM_MAX;
      cnt++;
      if (by_age) forced++;
    end
    dev = (sum > cur_target) ? sum - cur_target : cur_target - sum;
    r.picked_count = CNT_W'(cnt);
    r.picked_sum = SUM_W'(sum);
    r.deviation = SUM_W'(dev);
    r.forced_count = CNT_W'(forced);
    r.hit = (cnt == cur_batch) && (dev * 10 <= cur_target);
    for (int i = 0; i < SLOTS; i++) begin
      if (!pool_live[i]) continue;
      if (r.picked_mask[i]) begin
        if (pool_decoded[i] != CNT_MAX) pool_decoded[i]++;
        pool_wait[i] = '0;
      end else if (pool_wait[i] != WAIT_MAX) begin
        pool_wait[i]++;
      end
      if (pool_decoded[i] >= pool_total[i]) begin
        pool_live[i] = 1'b0;
        r.done_mask[i] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_item(kind_e kind, logic [SLOT_W-1:0] slot = '0,
                           logic [LEN_W-1:0] plen = '0, logic [LEN_W-1:0] dtot = '0,
                           logic [LEN_W-1:0] dstart = '0);
    int unsigned gap;
    batch_res_t exp_item;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_DATA_W'({dstart, dtot, plen, slot});
    do @(posedge clk_i); while (!s_axis_tready);
    exp_item = schedule_item(kind, slot, plen, dtot, dstart);
    pending_batches = {pending_batches, exp_item};
  endtask

  task automatic load_slot(logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] plen,
                           logic [LEN_W-1:0] dtot, logic [LEN_W-1:0] dstart);
    send_item(KIND_LOAD, slot, plen, dtot, dstart);
  endtask

  task automatic run_round();
    send_item(KIND_ROUND);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_batches.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [SUM_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TARGET: cur_target = value;
      CFG_BATCH:  cur_batch = value[CNT_W-1:0];
      CFG_AGE:    cur_age = value[WAIT_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_policy(logic [SUM_W-1:0] target, logic [SUM_W-1:0] batch,
                            logic [SUM_W-1:0] age);
    drain();
    write_reg(CFG_TARGET, target);
    write_reg(CFG_BATCH, batch);
    write_reg(CFG_AGE, age);
  endtask

  task automatic load_random();
    logic [LEN_W-1:0] plen, dstart, dtot;
    plen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 4000));
    dstart = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 500));
    if ($urandom_range(0, 5) == 0) dtot = LEN_W'($urandom);
    else dtot = LEN_W'(dstart + $urandom_range(0, 4));
    if (dtot < dstart && $urandom_range(0, 1) == 1) dtot = CNT_MAX;
    load_slot(SLOT_W'($urandom_range(0, SLOTS - 1)), plen, dtot, dstart);
  endtask

  task automatic test_directed_rounds();
    load_slot(6'd0, CNT_MAX, CNT_MAX, CNT_MAX);
    load_slot(6'd63, '0, 20'd3, '0);
    load_slot(6'd5, 20'd12345, 20'd2, '0);
    load_slot(6'd7, 20'd12345, 20'd5, '0);
    run_round();
    run_round();
    run_round();
    run_round();
    run_round();
    run_round();
    run_round();
  endtask

  task automatic test_config_edges();
    set_policy('0, 7'd64, 16'd2);
    load_slot(6'd1, 20'd100, 20'd10, '0);
    run_round();
    set_policy(20000, '0, 16'd2);
    run_round();
    set_policy(SUM_MAX, 7'd127, '0);
    load_slot(6'd2, 20'd50, 20'd10, '0);
    load_slot(6'd3, 20'd70, 20'd10, '0);
    run_round();
    set_policy(300, 7'd2, WAIT_MAX);
    load_slot(6'd4, 20'd150, 20'd9, 20'd1);
    run_round();
    run_round();
  endtask

  task automatic test_receiver_holdoff();
    set_policy(60000, 7'd16, 16'd2);
    holdoff_req = 1'b1;
    repeat (12) load_random();
    run_round();
    drain();
  endtask

  task automatic test_random_phase(int unsigned items);
    repeat (items) begin
      if ($urandom_range(0, 9) < 6) load_random();
      else run_round();
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  task automatic test_random_policies();
    set_policy(20000, 7'd8, 16'd2);
    test_random_phase(28);
    set_policy(SUM_W'($urandom), CNT_W'($urandom_range(1, 64)), WAIT_W'($urandom_range(0, 5)));
    test_random_phase(28);
    quiet = 1'b1;
    set_policy(5000, 7'd3, WAIT_MAX);
    test_random_phase(28);
    quiet = 1'b0;
    set_policy(SUM_MAX, 7'd64, 16'd1);
    test_random_phase(28);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      pool_wait[i] = '0;
      pool_live[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_rounds();
    test_config_edges();
    test_receiver_holdoff();
    test_random_policies();
    drain();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side flow control
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  always @(posedge clk_i) begin
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (m_axis_tvalid && m_axis_tready && !quiet) stall_left = $urandom_range(0, 7);
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    batch_res_t want;
    batch_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.picked_mask = m_axis_tdata[63:0];
      got.picked_count = m_axis_tdata[70:64];
      got.picked_sum = m_axis_tdata[97:71];
      got.deviation = m_axis_tdata[124:98];
      got.forced_count = m_axis_tdata[131:125];
      got.hit = m_axis_tdata[132];
      got.done_mask = m_axis_tdata[196:133];
      if (pending_batches.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        want = pending_batches.pop_front();
        if (got.picked_mask !== want.picked_mask) begin
          $error("picked_mask: expected %h, got %h", want.picked_mask, got.picked_mask);
          error_count++;
        end
        if (got.picked_count !== want.picked_count) begin
          $error("picked_count: expected %0d, got %0d", want.picked_count, got.picked_count);
          error_count++;
        end
        if (got.picked_sum !== want.picked_sum) begin
          $error("picked_sum: expected %0d, got %0d", want.picked_sum, got.picked_sum);
          error_count++;
        end
        if (got.deviation !== want.deviation) begin
          $error("deviation: expected %0d, got %0d", want.deviation, got.deviation);
          error_count++;
        end
        if (got.forced_count !== want.forced_count) begin
          $error("forced_count: expected %0d, got %0d", want.forced_count, got.forced_count);
          error_count++;
        end
        if (got.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, got.hit);
          error_count++;
        end
        if (got.done_mask !== want.done_mask) begin
          $error("done_mask: expected %h, got %h", want.done_mask, got.done_mask);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
